// File: hdl/sha256_digest_table_match_core_assert.svh
// assertion macros for the digest table match core
// used by the top level and the hash engine
`ifndef SHA256_DIGEST_TABLE_MATCH_CORE_ASSERT_SVH
`define SHA256_DIGEST_TABLE_MATCH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SDTM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SDTM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SDTM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SDTM_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/sdtm_pkg.sv
// shared constants and functions for the digest table match core
// no dependencies
package sdtm_pkg;
    localparam int MaxHashes  = 32;
    localparam int MaxWordLen = 6;
    localparam int EntryW     = $clog2(MaxHashes);
    localparam int AddrW      = EntryW + 2;
    localparam int CountW     = 6;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;
    localparam logic [1:0] REG_HASH_COUNT = 2'd0;

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

// File: hdl/sdtm_hash.sv
// iterative sha-256 engine, one round per cycle over a single padded block
// depends on sdtm_pkg
module sdtm_hash import sdtm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [47:0]  word_chars,
    input  logic [2:0]   word_len,
    output logic         done,
    output logic [255:0] digest
);
    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FINAL} state_t;
    state_t state_reg;
    logic [5:0] round_reg;
    logic [31:0] w_reg [16];
    logic [255:0] v_reg;
    logic [255:0] digest_reg;
    logic done_reg;

    logic [511:0] blk;
    logic [2:0] len;
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, w_new, w_cur;
    logic [255:0] v_next;

    always_comb begin
        len = (word_len > 3'(MaxWordLen)) ? 3'(MaxWordLen) : word_len;
        blk = '0;
        for (int i = 0; i < 6; i++) begin
            if (3'(i) < len) blk[511 - 8*i -: 8] = word_chars[47 - 8*i -: 8];
        end
        blk[511 - 8*len -: 8] = 8'h80;
        blk[7:0] = {2'b00, len, 3'b000};
    end

    always_comb begin
        {a, b, c, d, e, f, g, h} = v_reg;
        w_cur = w_reg[0];
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + round_k(round_reg) + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        v_next = {t1 + t2, a, b, c, d + t1, e, f, g};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            round_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        for (int i = 0; i < 16; i++) w_reg[i] <= blk[511 - 32*i -: 32];
                        v_reg <= H_INIT;
                        round_reg <= '0;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    v_reg <= v_next;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_new;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63) state_reg <= S_FINAL;
                end
                S_FINAL: begin
                    for (int i = 0; i < 8; i++)
                        digest_reg[255 - 32*i -: 32] <= H_INIT[255 - 32*i -: 32]
                                                       + v_reg[255 - 32*i -: 32];
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign digest = digest_reg;

    `include "sha256_digest_table_match_core_assert.svh"
    `SDTM_ASSERT_NEXT(a_start_rounds, aclk, aresetn, state_reg == S_IDLE && start, state_reg == S_ROUND && round_reg == 6'd0)
    `SDTM_ASSERT_NEXT(a_final_done, aclk, aresetn, state_reg == S_FINAL, done_reg)
    `SDTM_ASSERT_IMP(a_done_idle, aclk, aresetn, done_reg, state_reg == S_IDLE)
endmodule

// File: hdl/sha256_digest_table_match_core.sv
// load transfers write one digest quarter. check transfers hash the word, then scan entries below
// hash_count (at most 32), skipping found entries and reading four quarters per unfound one,
// with result stalls able to hold the scan
// one item at a time; throughput set by the round loop and the single memory read port
// aresetn synchronous active low clears control, hash_count and found flags
// digest memory is undefined until loaded
module sha256_digest_table_match_core import sdtm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [4:0]  s_entry_index,
    input  logic [1:0]  s_quarter_sel,
    input  logic [63:0] s_digest_quarter,
    input  logic [47:0] s_word_chars,
    input  logic [2:0]  s_word_len,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_match_number,
    output logic        m_last_match,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [2:0] {S_IDLE, S_HASH, S_SCAN, S_CMP, S_OUT} state_t;
    state_t state_reg;
    logic [CountW-1:0] hash_count_reg;
    logic [MaxHashes-1:0] found_reg;
    logic [63:0] mem [4*MaxHashes];
    logic [63:0] rd_reg;
    logic [AddrW-1:0] addr_reg;
    logic rd_valid_reg, eq_reg, pend_reg;
    logic [EntryW:0] ent_reg, limit;
    logic [EntryW-1:0] pend_ent_reg;
    logic [5:0] m_num_reg;
    logic m_last_reg, m_valid_reg;
    logic hash_done;
    logic [255:0] digest;
    logic start;
    logic [63:0] q_sel;
    logic emit;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HASH_COUNT[0]) ? {26'd0, hash_count_reg} : 32'd0;
    assign s_ready = (state_reg == S_IDLE);
    assign start = s_valid && s_ready && s_req_type == REQ_CHECK;
    assign limit = (hash_count_reg > CountW'(MaxHashes)) ? (EntryW+1)'(MaxHashes)
                                                         : (EntryW+1)'(hash_count_reg);
    assign q_sel = digest[255 - 64*addr_reg[1:0] -: 64];
    // a result transfer is loaded this cycle
    assign emit = pend_reg && (!m_valid_reg || m_ready)
                  && (state_reg == S_OUT
                      || (state_reg == S_CMP && rd_valid_reg && addr_reg[1:0] == 2'd3
                          && eq_reg && rd_reg == q_sel));

    sdtm_hash u_hash (
        .aclk(aclk), .aresetn(aresetn), .start(start), .word_chars(s_word_chars),
        .word_len(s_word_len), .done(hash_done), .digest(digest));

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_req_type == REQ_LOAD)
            mem[{s_entry_index, s_quarter_sel}] <= s_digest_quarter;
        rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hash_count_reg <= '0;
            found_reg <= '0;
            m_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == 3'd0)
                hash_count_reg <= pwdata[CountW-1:0];
            if (m_valid_reg && m_ready && !emit) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_req_type == REQ_LOAD) found_reg[s_entry_index] <= 1'b0;
                        else state_reg <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        ent_reg <= '0;
                        addr_reg <= '0;
                        eq_reg <= 1'b1;
                        rd_valid_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // skip found entries and end the scan at the first out-of-range entry
                    if (ent_reg >= limit) state_reg <= S_OUT;
                    else if (found_reg[ent_reg[EntryW-1:0]]) ent_reg <= ent_reg + 1'b1;
                    else begin
                        addr_reg <= {ent_reg[EntryW-1:0], 2'd0};
                        eq_reg <= 1'b1;
                        rd_valid_reg <= 1'b0;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    // rd_reg is a registered read of the quarter at addr_reg
                    if (!rd_valid_reg) rd_valid_reg <= 1'b1;
                    else begin
                        if (addr_reg[1:0] != 2'd3) begin
                            eq_reg <= eq_reg && (rd_reg == q_sel);
                            addr_reg <= addr_reg + 1'b1;
                            rd_valid_reg <= 1'b0;
                        end else if (eq_reg && rd_reg == q_sel) begin
                            if (!pend_reg || !m_valid_reg || m_ready) begin
                                found_reg[ent_reg[EntryW-1:0]] <= 1'b1;
                                if (pend_reg) begin
                                    m_num_reg <= 6'(pend_ent_reg) + 6'd1;
                                    m_last_reg <= 1'b0;
                                    m_valid_reg <= 1'b1;
                                end
                                pend_reg <= 1'b1;
                                pend_ent_reg <= ent_reg[EntryW-1:0];
                                ent_reg <= ent_reg + 1'b1;
                                state_reg <= S_SCAN;
                            end
                        end else begin
                            ent_reg <= ent_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_OUT: begin
                    if (!pend_reg) state_reg <= S_IDLE;
                    else if (!m_valid_reg || m_ready) begin
                        m_num_reg <= 6'(pend_ent_reg) + 6'd1;
                        m_last_reg <= 1'b1;
                        m_valid_reg <= 1'b1;
                        pend_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_match_number = m_num_reg;
    assign m_last_match = m_last_reg;

    `include "sha256_digest_table_match_core_assert.svh"
    `SDTM_ASSERT_IMP(a_busy_not_ready, aclk, aresetn, state_reg != S_IDLE, !s_ready)
    `SDTM_ASSERT_NEXT(a_check_starts, aclk, aresetn, s_valid && s_ready && s_req_type == REQ_CHECK, state_reg == S_HASH)
    `SDTM_ASSERT_IMP(a_idle_no_pend, aclk, aresetn, state_reg == S_IDLE, !pend_reg)
endmodule

// File: test/sha256_digest_table_match_core_tb.sv
// testbench for sha256_digest_table_match_core: loads digest tables, checks candidate words
// against a predictor with its own sha-256 and table copy; depends on sdtm_pkg and the rtl
`timescale 1ns / 100ps

class match_scoreboard;
    typedef struct packed {
        logic [5:0] number;
        logic       last;
    } match_t;

    match_t      pending[$];
    logic [63:0] quarters[128];
    bit          found[32];
    int unsigned hash_count;
    int          errors;
    int          results;
    int          checks;
    int          loads;

    static const bit [31:0] kc[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    static const bit [31:0] hc[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    static function bit [31:0] ror(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // digest of the first len bytes, h0 in the top bits
    static function logic [255:0] word_digest(logic [47:0] chars, int len);
        bit [7:0]  blk[64];
        bit [31:0] w[64];
        bit [31:0] v[8];
        bit [31:0] t1, t2;
        logic [255:0] d;
        if (len > 6) len = 6;
        foreach (blk[i]) blk[i] = 8'h00;
        for (int i = 0; i < len; i++) blk[i] = chars[47 - 8 * i -: 8];
        blk[len] = 8'h80;
        blk[63] = 8'(len * 8);
        for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hc[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) d[255 - 32 * i -: 32] = hc[i] + v[i];
        return d;
    endfunction

    function void set_count(logic [31:0] value);
        hash_count = value[5:0];
    endfunction

    function void note_input(logic rt, logic [4:0] ent, logic [1:0] qs, logic [63:0] dq,
                             logic [47:0] wc, logic [2:0] wl);
        logic [255:0] d;
        int limit;
        int first;
        if (rt == sdtm_pkg::REQ_LOAD) begin
            quarters[ent * 4 + qs] = dq;
            found[ent] = 0;
            loads++;
            return;
        end
        checks++;
        d = word_digest(wc, wl);
        limit = (hash_count > 32) ? 32 : hash_count;
        first = pending.size();
        for (int e = 0; e < limit; e++) begin
            if (!found[e] && {quarters[e*4], quarters[e*4+1], quarters[e*4+2],
                              quarters[e*4+3]} == d) begin
                found[e] = 1;
                pending.push_back('{number: 6'(e + 1), last: 1'b0});
            end
        end
        if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(logic [5:0] number, logic last);
        match_t exp_m;
        results++;
        if (pending.size() == 0) begin
            report($sformatf("unexpected match %0d last %0b", number, last));
            return;
        end
        exp_m = pending.pop_front();
        if (number !== exp_m.number)
            report($sformatf("match_number %0d, expected %0d", number, exp_m.number));
        if (last !== exp_m.last)
            report($sformatf("last_match %0b, expected %0b", last, exp_m.last));
    endtask
endclass

module sha256_digest_table_match_core_tb;
    import sdtm_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = REQ_LOAD;
    logic [4:0]  s_entry_index = '0;
    logic [1:0]  s_quarter_sel = '0;
    logic [63:0] s_digest_quarter = '0;
    logic [47:0] s_word_chars = '0;
    logic [2:0]  s_word_len = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_match_number;
    logic        m_last_match;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    match_scoreboard sb = new();
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_request = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   items = 0;

    logic [47:0]  pool_chars[6];
    int           pool_len[6];
    logic [255:0] pool_digest[6];

    sha256_digest_table_match_core i_dut (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request || hold_left > 0) begin
            if (hold_request) begin
                hold_left = 400;
                hold_request = 0;
            end
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_match_number, m_last_match);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task push(logic rt, logic [4:0] ent, logic [1:0] qs, logic [63:0] dq,
              logic [47:0] wc, logic [2:0] wl);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid          <= 1'b1;
        s_req_type       <= rt;
        s_entry_index    <= ent;
        s_quarter_sel    <= qs;
        s_digest_quarter <= dq;
        s_word_chars     <= wc;
        s_word_len       <= wl;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(rt, ent, qs, dq, wc, wl);
        items++;
    endtask

    function logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task load_entry(logic [4:0] ent, logic [255:0] d);
        for (int q = 0; q < 4; q++)
            push(REQ_LOAD, ent, 2'(q), d[255 - 64 * q -: 64], 48'(rand64()), 3'($urandom));
    endtask

    task check_pool(int p);
        logic [47:0] mask;
        logic [2:0]  len;
        mask = (pool_len[p] == 0) ? '0 : ~48'h0 << (48 - 8 * pool_len[p]);
        len = (pool_len[p] == 6 && $urandom_range(1)) ? 3'd7 : 3'(pool_len[p]);
        push(REQ_CHECK, 5'($urandom), 2'($urandom), rand64(),
             (pool_chars[p] & mask) | (48'(rand64()) & ~mask), len);
    endtask

    task drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task write_count(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_HASH_COUNT * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_count(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            load_entry(5'($urandom), pool_digest[$urandom_range(5)]);
        end else if (pick < 30) begin
            push(REQ_LOAD, 5'($urandom), 2'($urandom), rand64(), 48'(rand64()), 3'($urandom));
        end else if (pick < 88) begin
            check_pool($urandom_range(5));
        end else begin
            push(REQ_CHECK, 5'($urandom), 2'($urandom), rand64(), 48'(rand64()),
                 3'($urandom));
        end
    endtask

    initial begin
        int counts[6];
        int mode;
        int target;
        counts = '{32, 63, 7, 20, 1, 32};
        for (int p = 0; p < 6; p++) begin
            pool_len[p] = (p == 0) ? 0 : (p == 1) ? 6 : $urandom_range(1, 6);
            pool_chars[p] = 48'(rand64());
            pool_digest[p] = sb.word_digest(pool_chars[p], pool_len[p]);
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_count(0);
        // count zero: checks read nothing
        push(REQ_CHECK, 5'h1f, 2'd3, '1, '1, 3'd7);
        push(REQ_CHECK, 5'h00, 2'd0, '0, '0, 3'd0);
        // fill every entry before any count lets checks read it
        for (int e = 0; e < 32; e++)
            if (e % 5 == 4) load_entry(5'(e), {rand64(), rand64(), rand64(), rand64()});
            else load_entry(5'(e), pool_digest[e % 6]);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_count(counts[ph]);
            mode = ph % 4;
            send_idle_pct  = (mode == 1) ? 56 : (mode == 3) ? 36 : 0;
            recv_stall_pct = (mode == 2) ? 56 : (mode == 3) ? 36 : 0;
            if (ph == 0) begin
                for (int p = 0; p < 6; p++) check_pool(p);
                push(REQ_CHECK, 5'h1f, 2'd3, '1, '1, 3'd7);
                push(REQ_CHECK, 5'h00, 2'd0, '0, '0, 3'd0);
            end
            if (ph == 2) begin
                hold_request = 1;
                for (int i = 0; i < 8; i++) check_pool($urandom_range(5));
            end
            target = items + 32;
            while (items < target) begin
                random_item();
                if (ph == 4 && items == target - 16) begin
                    // sender waits for every outstanding match
                    s_valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end
        $display("covered %0d loads and %0d checks over counts 0..63, %0d matches",
                 sb.loads, sb.checks, sb.results);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: sha256_digest_table_match_core.f
+incdir+hdl
hdl/sdtm_pkg.sv
hdl/sdtm_hash.sv
hdl/sha256_digest_table_match_core.sv
test/sha256_digest_table_match_core_tb.sv
